FILE: rtl/rbrld_pkg.sv
package rbrld_pkg;

  // Grid and coordinate geometry
  localparam int unsigned GRID_DIM   = 1024;
  localparam int unsigned CellW      = $clog2(GRID_DIM);
  localparam int unsigned CoordW     = 16;
  localparam int unsigned ColorW     = 5;
  localparam int unsigned CharW      = 8;
  localparam int unsigned ModeW      = 2;

  // Repeat letters span 'A'..'Z'
  localparam int unsigned MAX_REPEAT = 26;
  localparam int unsigned CountW     = 5;

  localparam int unsigned QUEUE_DEPTH = 2;

  // Character codes
  localparam logic [CharW-1:0] CharZero = 8'h30;
  localparam logic [CharW-1:0] CharNine = 8'h39;
  localparam logic [CharW-1:0] CharA    = 8'h41;
  localparam logic [CharW-1:0] CharM    = 8'h4D;
  localparam logic [CharW-1:0] CharP    = 8'h50;
  localparam logic [CharW-1:0] CharZ    = 8'h5A;

  // Colour table modes
  localparam logic [ModeW-1:0] ModePrcp = 2'd1;
  localparam logic [ModeW-1:0] ModeClar = 2'd2;

  localparam logic [ColorW-1:0] ColorGeneric = 5'd1;

  localparam logic [ColorW-1:0] PrcpColors [10] = '{
    5'd0, 5'd23, 5'd22, 5'd21, 5'd20, 5'd17, 5'd15, 5'd0, 5'd0, 5'd0
  };
  localparam logic [ColorW-1:0] ClarColors [10] = '{
    5'd0, 5'd24, 5'd25, 5'd26, 5'd27, 5'd28, 5'd29, 5'd0, 5'd0, 5'd0
  };

  // Cursor reset: one grid cell west and south of zero
  localparam logic [CoordW-1:0] CursorReset = 16'hFFFC;

  typedef enum logic [1:0] {
    OP_START,
    OP_DIGIT,
    OP_REPEAT
  } op_e;

  typedef struct packed {
    logic              kind;
    logic [CharW-1:0]  code_char;
    logic [CellW-1:0]  base_col;
    logic [CellW-1:0]  base_row;
    logic [CharW-1:0]  row_letter;
    logic [CharW-1:0]  col_letter;
    logic [CharW-1:0]  sub_letter;
    logic [ModeW-1:0]  mode;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] box_col;
    logic signed [CoordW-1:0] box_row;
    logic [ColorW-1:0]        box_color;
    logic                     last;
  } out_item_t;

  // Classified command handed from the front to the back
  typedef struct packed {
    op_e               op;
    logic [CoordW-1:0] origin_col;
    logic [CoordW-1:0] origin_row;
    logic [ColorW-1:0] color;
    logic [CountW-1:0] count;
  } cmd_t;

  function automatic logic [ColorW-1:0] color_of(input logic [ModeW-1:0] mode,
                                                 input logic [3:0] digit);
    logic [ColorW-1:0] color;
    color = ColorGeneric;
    if (mode == ModePrcp) begin
      color = PrcpColors[digit];
    end else if (mode == ModeClar) begin
      color = ClarColors[digit];
    end
    return color;
  endfunction

endpackage

FILE: rtl/radar_box_run_length_decoder.sv
// Radar run-string box decoder. Feed one coded-message run string as a
// sequence of input transactions: a start transaction (kind 0) carries the
// base grid cell, the three box letters and the colour table mode; each
// following code-character transaction (kind 1) is a digit, which places one
// quarter-cell box, or a letter A..Z, which repeats the last digit colour 1 to
// MaxRepeat times while stepping one quarter east. Every emitted box is one
// output transaction with its west and north edges in quarter-grid units
// (16-bit two's complement, wrapping), its colour, and last set on the final
// box caused by one input transaction; colour-zero boxes advance the cursor
// but are not emitted, and other characters are dropped. Timing: the front
// accepts one input transaction per cycle while its command queue (Depth
// entries) has room, and drops ignored characters in that same cycle. The
// back executes queued commands in order: a start or a digit is handled as
// it is popped, and a repeat letter first loads its count and then places
// one box per repeat (up to MaxRepeat), popping no new command until the
// run is done. The back places one box per cycle while its single output
// register is free to take it; output back-pressure stalls only the back,
// and the front keeps accepting until the queue fills.
module radar_box_run_length_decoder #(
  parameter int unsigned MaxRepeat  = rbrld_pkg::MAX_REPEAT,
  parameter int unsigned QueueDepth = rbrld_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rbrld_pkg::in_item_t  in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rbrld_pkg::out_item_t out_o
);

  // Front to queue
  logic            q_push;
  logic            q_full;
  rbrld_pkg::cmd_t q_cmd_in;

  // Queue to back
  logic            q_valid;
  logic            q_pop;
  rbrld_pkg::cmd_t q_cmd_out;

  // Classify each transaction and precompute origin, colour and repeat count
  rbrld_front #(
    .MaxRepeat (MaxRepeat)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_cmd_in)
  );

  // Decouple acceptance from box generation
  rbrld_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd_out)
  );

  // Hold origin and cursor, walk repeat runs, drive the output register
  rbrld_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd_out),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

FILE: rtl/rbrld_front.sv
module rbrld_front #(
  parameter int unsigned MaxRepeat = rbrld_pkg::MAX_REPEAT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rbrld_pkg::in_item_t in_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output rbrld_pkg::cmd_t     q_cmd_o
);

  logic [rbrld_pkg::ModeW-1:0]  table_mode_q, table_mode_d;
  logic                         accept;
  logic                         is_digit;
  logic                         is_letter;
  logic                         sub_ok;
  logic [rbrld_pkg::CharW-1:0]  sub_idx;
  logic [rbrld_pkg::CharW-1:0]  digit_full;
  logic [rbrld_pkg::CharW-1:0]  rep_full;
  logic [rbrld_pkg::CoordW-1:0] col_cell;
  logic [rbrld_pkg::CoordW-1:0] row_cell;
  logic [rbrld_pkg::CoordW-1:0] sub_col;
  logic [rbrld_pkg::CoordW-1:0] sub_row;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign is_digit  = (in_i.code_char >= rbrld_pkg::CharZero) &&
                     (in_i.code_char <= rbrld_pkg::CharNine);
  assign is_letter = (in_i.code_char >= rbrld_pkg::CharA) &&
                     (in_i.code_char <= rbrld_pkg::CharZ);

  assign digit_full = in_i.code_char - rbrld_pkg::CharZero;
  assign rep_full   = in_i.code_char - rbrld_pkg::CharA + 8'd1;

  // Sub-box letter: upper two bits step east, lower two step south
  assign sub_ok  = (in_i.sub_letter >= rbrld_pkg::CharA) &&
                   (in_i.sub_letter <= rbrld_pkg::CharP);
  assign sub_idx = in_i.sub_letter - rbrld_pkg::CharA;
  assign sub_col = sub_ok ? {14'd0, sub_idx[3:2]} : '0;
  assign sub_row = sub_ok ? {14'd0, sub_idx[1:0]} : '0;

  assign col_cell = rbrld_pkg::CoordW'(in_i.base_col) + {8'd0, in_i.col_letter}
                    - {8'd0, rbrld_pkg::CharM};
  assign row_cell = rbrld_pkg::CoordW'(in_i.base_row) + 16'd1
                    - ({8'd0, in_i.row_letter} - {8'd0, rbrld_pkg::CharM});

  always_comb begin
    q_cmd_o            = '0;
    q_cmd_o.origin_col = {col_cell[13:0], 2'b00} + sub_col;
    q_cmd_o.origin_row = {row_cell[13:0], 2'b00} - sub_row;
    q_cmd_o.color      = rbrld_pkg::color_of(table_mode_q, digit_full[3:0]);
    if (rep_full > 8'(MaxRepeat)) begin
      q_cmd_o.count = rbrld_pkg::CountW'(MaxRepeat);
    end else begin
      q_cmd_o.count = rep_full[rbrld_pkg::CountW-1:0];
    end
    if (!in_i.kind) begin
      q_cmd_o.op = rbrld_pkg::OP_START;
    end else if (is_digit) begin
      q_cmd_o.op = rbrld_pkg::OP_DIGIT;
    end else begin
      q_cmd_o.op = rbrld_pkg::OP_REPEAT;
    end
  end

  // Drop characters that are neither digits nor repeat letters
  assign q_push_o = accept && (!in_i.kind || is_digit || is_letter);

  assign table_mode_d = (accept && !in_i.kind) ? in_i.mode : table_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_mode_q <= '0;
    end else begin
      table_mode_q <= table_mode_d;
    end
  end

endmodule

FILE: rtl/rbrld_queue.sv
module rbrld_queue #(
  parameter int unsigned Depth = rbrld_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rbrld_pkg::cmd_t cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output rbrld_pkg::cmd_t cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  rbrld_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue pushed while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue popped while empty");

endmodule

FILE: rtl/rbrld_back.sv
module rbrld_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  rbrld_pkg::cmd_t      cmd_i,
  output logic                 cmd_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rbrld_pkg::out_item_t out_o
);

  logic [rbrld_pkg::CoordW-1:0] origin_col_q, origin_col_d;
  logic [rbrld_pkg::CoordW-1:0] origin_row_q, origin_row_d;
  logic [rbrld_pkg::CoordW-1:0] cursor_col_q, cursor_col_d;
  logic [rbrld_pkg::CoordW-1:0] cursor_row_q, cursor_row_d;
  logic [rbrld_pkg::ColorW-1:0] run_color_q, run_color_d;
  logic                         seen_digit_q, seen_digit_d;
  logic [rbrld_pkg::CountW-1:0] rep_left_q, rep_left_d;
  logic                         out_valid_q, out_valid_d;
  rbrld_pkg::out_item_t         out_q, box;
  logic                         out_free;
  logic                         emit;

  assign out_free    = !out_valid_q || out_ready_i;
  assign cmd_pop_o   = cmd_valid_i && (rep_left_q == '0) && out_free;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    origin_col_d = origin_col_q;
    origin_row_d = origin_row_q;
    cursor_col_d = cursor_col_q;
    cursor_row_d = cursor_row_q;
    run_color_d  = run_color_q;
    seen_digit_d = seen_digit_q;
    rep_left_d   = rep_left_q;
    emit         = 1'b0;
    box          = '0;

    if (rep_left_q != '0) begin
      if (out_free) begin
        cursor_col_d  = cursor_col_q + 1'b1;
        rep_left_d    = rep_left_q - 1'b1;
        emit          = (run_color_q != '0);
        box.box_col   = cursor_col_d;
        box.box_row   = cursor_row_q;
        box.box_color = run_color_q;
        box.last      = (rep_left_q == rbrld_pkg::CountW'(1));
      end
    end else if (cmd_pop_o) begin
      unique case (cmd_i.op)
        rbrld_pkg::OP_START: begin
          origin_col_d = cmd_i.origin_col;
          origin_row_d = cmd_i.origin_row;
          run_color_d  = '0;
          seen_digit_d = 1'b0;
        end
        rbrld_pkg::OP_DIGIT: begin
          if (!seen_digit_q) begin
            cursor_col_d = origin_col_q;
            cursor_row_d = origin_row_q;
          end else begin
            cursor_col_d = cursor_col_q + 1'b1;
          end
          run_color_d   = cmd_i.color;
          seen_digit_d  = 1'b1;
          emit          = (cmd_i.color != '0);
          box.box_col   = cursor_col_d;
          box.box_row   = cursor_row_d;
          box.box_color = cmd_i.color;
          box.last      = 1'b1;
        end
        rbrld_pkg::OP_REPEAT: begin
          rep_left_d = cmd_i.count;
        end
        default: begin
        end
      endcase
    end

    out_valid_d = emit || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_col_q <= '0;
      origin_row_q <= '0;
      cursor_col_q <= rbrld_pkg::CursorReset;
      cursor_row_q <= rbrld_pkg::CursorReset;
      run_color_q  <= '0;
      seen_digit_q <= 1'b0;
      rep_left_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      origin_col_q <= origin_col_d;
      origin_row_q <= origin_row_d;
      cursor_col_q <= cursor_col_d;
      cursor_row_q <= cursor_row_d;
      run_color_q  <= run_color_d;
      seen_digit_q <= seen_digit_d;
      rep_left_q   <= rep_left_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= box;
    end
  end

  a_color_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.box_color != '0))
    else $error("box with colour zero presented");

  a_no_pop_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rep_left_q != '0) |-> !cmd_pop_o)
    else $error("command popped during a repeat run");

  a_run_ends_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rep_left_q == rbrld_pkg::CountW'(1) && out_free && run_color_q != '0)
    |=> (out_valid_q && out_q.last))
    else $error("final box of a repeat run not marked last");

endmodule
